>>> rtl/rfa_pkg.sv
`timescale 1ns / 1ps
// Package for the reduced fraction adder: operand widths, word types and
// the status struct that the iterative units report to the sequencer.
// No dependencies.
package rfa_pkg;

	// Operand width and the widths that follow from it
	localparam int OPND_W = 16;
	localparam int DEN_W  = 2 * OPND_W;
	localparam int NUM_W  = 2 * OPND_W + 1;
	// Counter wide enough to hold NUM_W itself
	localparam int CNT_W  = $clog2(NUM_W + 1);

	// Input word: two fractions
	typedef struct packed {
		logic [OPND_W-1:0] first_num;
		logic [OPND_W-1:0] first_den;
		logic [OPND_W-1:0] second_num;
		logic [OPND_W-1:0] second_den;
	} opnd_t;

	// Output word: reduced sum
	typedef struct packed {
		logic [NUM_W-1:0] sum_num;
		logic [DEN_W-1:0] sum_den;
	} res_t;

	// Status of an iterative unit
	typedef struct packed {
		logic busy;
		logic done;
	} unit_stat_t;

endpackage

>>> rtl/rfa_gcd.sv
`timescale 1ns / 1ps
// Binary (Stein) gcd unit: one compare/subtract and shift per cycle.
// Depends on rfa_pkg. Both operands must be nonzero at start.
module rfa_gcd (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rfa_pkg::NUM_W-1:0] a,
	input  logic [rfa_pkg::NUM_W-1:0] b,
	output rfa_pkg::unit_stat_t       stat,
	output logic [rfa_pkg::NUM_W-1:0] g
);
	import rfa_pkg::*;

	logic [NUM_W-1:0] a_q;
	logic [NUM_W-1:0] b_q;
	logic [NUM_W-1:0] g_q;
	logic [CNT_W-1:0] k_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W:0]   d_ab;
	logic [NUM_W-1:0] d_ba;
	logic             a_gt;
	logic             equal;

	// Shared compare/subtract
	assign d_ab  = {1'b0, a_q} - {1'b0, b_q};
	assign d_ba  = b_q - a_q;
	assign a_gt  = !d_ab[NUM_W];
	assign equal = (a_q == b_q);

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && equal) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// Datapath: strip common twos, then odd-odd subtract with halving
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= a;
			b_q <= b;
			k_q <= '0;
		end else if (busy_q) begin
			priority if (equal) begin
				g_q <= a_q << k_q;
			end else if (!a_q[0] && !b_q[0]) begin
				a_q <= a_q >> 1;
				b_q <= b_q >> 1;
				k_q <= k_q + CNT_W'(1);
			end else if (!a_q[0]) begin
				a_q <= a_q >> 1;
			end else if (!b_q[0]) begin
				b_q <= b_q >> 1;
			end else if (a_gt) begin
				a_q <= d_ab[NUM_W-1:0] >> 1;
			end else begin
				b_q <= d_ba >> 1;
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign g         = g_q;

	// Checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("gcd started while busy");
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (a_q != '0 && b_q != '0)) else $error("gcd operand went to zero");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q))) else $error("gcd done without run");
	a_g_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (g_q != '0)) else $error("gcd result is zero");

endmodule

>>> rtl/rfa_div.sv
`timescale 1ns / 1ps
// Two-lane restoring divider: both dividends by one shared divisor,
// one quotient bit per lane per cycle. Depends on rfa_pkg.
module rfa_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [rfa_pkg::NUM_W-1:0] divisor,
	input  logic [rfa_pkg::NUM_W-1:0] dvd_a,
	input  logic [rfa_pkg::NUM_W-1:0] dvd_b,
	output rfa_pkg::unit_stat_t       stat,
	output logic [rfa_pkg::NUM_W-1:0] quo_a,
	output logic [rfa_pkg::NUM_W-1:0] quo_b
);
	import rfa_pkg::*;

	logic [NUM_W-1:0] dvs_q;
	logic [NUM_W-1:0] qa_q;
	logic [NUM_W-1:0] qb_q;
	logic [NUM_W-1:0] ra_q;
	logic [NUM_W-1:0] rb_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [NUM_W:0]   ta;
	logic [NUM_W:0]   tb;
	logic [NUM_W:0]   sa;
	logic [NUM_W:0]   sb;
	logic             ge_a;
	logic             ge_b;
	logic             last;

	// Shift in next dividend bit and trial-subtract
	assign ta   = {ra_q, qa_q[NUM_W-1]};
	assign tb   = {rb_q, qb_q[NUM_W-1]};
	assign sa   = ta - {1'b0, dvs_q};
	assign sb   = tb - {1'b0, dvs_q};
	assign ge_a = (ta >= {1'b0, dvs_q});
	assign ge_b = (tb >= {1'b0, dvs_q});
	assign last = (cnt_q == CNT_W'(NUM_W - 1));

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CNT_W'(1);
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: dividend registers turn into quotients
	always_ff @(posedge clk) begin
		if (start) begin
			dvs_q <= divisor;
			qa_q  <= dvd_a;
			qb_q  <= dvd_b;
			ra_q  <= '0;
			rb_q  <= '0;
		end else if (busy_q) begin
			qa_q <= {qa_q[NUM_W-2:0], ge_a};
			qb_q <= {qb_q[NUM_W-2:0], ge_b};
			ra_q <= ge_a ? sa[NUM_W-1:0] : ta[NUM_W-1:0];
			rb_q <= ge_b ? sb[NUM_W-1:0] : tb[NUM_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quo_a     = qa_q;
	assign quo_b     = qb_q;

	// Checks
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q) else $error("divider started while busy");
	a_dvs_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (dvs_q != '0)) else $error("divide by zero");
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (ra_q < dvs_q && rb_q < dvs_q)) else $error("remainder out of range");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && $past(busy_q))) else $error("divider done without run");

endmodule

>>> rtl/reduced_fraction_adder.sv
`timescale 1ns / 1ps
// Top level of the reduced fraction adder: sequencer, shared multiplier,
// gcd unit and divider. Depends on rfa_pkg, rfa_gcd, rfa_div.
//
//  channel  | valid       | stall       | word
//  ---------+-------------+-------------+----------------------------------
//  operand  | opnd_valid  | opnd_stall  | opnd: first/second num and den
//  result   | res_valid   | res_stall   | res:  sum_num, sum_den
//
// One word at a time. After accept, the shared 16x16 multiplier forms the
// products in steps DN, ND, DD and LAST; then the binary gcd loop runs, one
// subtract/shift per iteration; then the two-lane divider, unless the gcd is
// one; then the output is loaded. Zero sum or zero denominator skips gcd and
// divide. Reset clears all control state. A stalled result waits in the
// output register while the next word is accepted and worked on.
module reduced_fraction_adder (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           opnd_valid,
	output logic           opnd_stall,
	input  rfa_pkg::opnd_t opnd,
	output logic           res_valid,
	input  logic           res_stall,
	output rfa_pkg::res_t  res
);
	import rfa_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_GCD  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_DONE = 5'b10000
	} state_t;

	// Multiplier steps
	localparam logic [1:0] MS_DN   = 2'd0;
	localparam logic [1:0] MS_ND   = 2'd1;
	localparam logic [1:0] MS_DD   = 2'd2;
	localparam logic [1:0] MS_LAST = 2'd3;

	state_t           state_q;
	logic [1:0]       step_q;
	opnd_t            opnd_q;
	logic [DEN_W-1:0] prod_q;
	logic [NUM_W-1:0] x_q;
	logic [DEN_W-1:0] y_q;
	res_t             res_q;
	logic             res_valid_q;

	logic [OPND_W-1:0] mul_a;
	logic [OPND_W-1:0] mul_b;
	logic              accept;
	logic              out_free;
	logic              res_load;
	logic              zero_case;
	logic              gcd_start;
	logic              div_start;
	unit_stat_t        gcd_stat;
	unit_stat_t        div_stat;
	logic [NUM_W-1:0]  gcd_g;
	logic [NUM_W-1:0]  quo_a;
	logic [NUM_W-1:0]  quo_b;
	logic              g_is_one;

	assign opnd_stall = (state_q != ST_IDLE);
	assign accept     = opnd_valid && !opnd_stall;
	assign out_free   = !res_valid_q || !res_stall;
	assign res_load   = (state_q == ST_DONE) && out_free;
	assign zero_case  = (x_q == '0) || (prod_q == '0);
	assign g_is_one   = (gcd_g == NUM_W'(1));
	assign gcd_start  = (state_q == ST_MUL) && (step_q == MS_LAST) && !zero_case;
	assign div_start  = (state_q == ST_GCD) && gcd_stat.done && !g_is_one;

	// Shared multiplier operand select
	always_comb begin
		mul_a = (step_q == MS_ND) ? opnd_q.first_num : opnd_q.first_den;
		mul_b = (step_q == MS_DN) ? opnd_q.second_num : opnd_q.second_den;
	end

	// Sequencer and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= MS_DN;
			res_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_MUL;
						step_q  <= MS_DN;
					end
				end
				ST_MUL: begin
					step_q <= step_q + 2'd1;
					if (step_q == MS_LAST) begin
						state_q <= zero_case ? ST_DONE : ST_GCD;
					end
				end
				ST_GCD: begin
					if (gcd_stat.done) begin
						state_q <= g_is_one ? ST_DONE : ST_DIV;
					end
				end
				ST_DIV: begin
					if (div_stat.done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath: operands, products, sum and final quotients
	always_ff @(posedge clk) begin
		if (accept) begin
			opnd_q <= opnd;
		end
		if (state_q == ST_MUL) begin
			prod_q <= mul_a * mul_b;
			unique case (step_q)
				MS_DN:   ;
				MS_ND:   x_q <= {1'b0, prod_q};
				MS_DD:   x_q <= x_q + {1'b0, prod_q};
				MS_LAST: y_q <= prod_q;
				default: ;
			endcase
		end
		if (state_q == ST_DIV && div_stat.done) begin
			x_q <= quo_a;
			y_q <= quo_b[DEN_W-1:0];
		end
		if (state_q == ST_DONE && out_free) begin
			res_q.sum_num <= x_q;
			res_q.sum_den <= y_q;
		end
	end

	rfa_gcd u_gcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (gcd_start),
		.a      (x_q),
		.b      ({1'b0, prod_q}),
		.stat   (gcd_stat),
		.g      (gcd_g)
	);

	rfa_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.divisor (gcd_g),
		.dvd_a   (x_q),
		.dvd_b   ({1'b0, y_q}),
		.stat    (div_stat),
		.quo_a   (quo_a),
		.quo_b   (quo_b)
	);

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// Checks
	a_gcd_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		gcd_stat.busy |-> (state_q == ST_GCD)) else $error("gcd busy outside its state");
	a_div_in_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.busy |-> (state_q == ST_DIV)) else $error("divider busy outside its state");
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_MUL && step_q == MS_DN)) else $error("accept lost");

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for reduced_fraction_adder: directed and random fraction
// pairs with random idling on both channels, results checked in order.
// Depends on rfa_pkg and the reduced_fraction_adder RTL.

// Holds the reduced sums still owed by the block, oldest first
class sum_scoreboard;
	typedef logic [rfa_pkg::NUM_W-1:0] wide_t;
	rfa_pkg::res_t pending_sums[$];
	int errors = 0;

	// Cross-multiplied sum reduced by Euclid; divisor is 1 on a zero side
	function rfa_pkg::res_t reduced_sum(rfa_pkg::opnd_t w);
		wide_t n1, d1, n2, d2, x, y, a, b, t, q;
		rfa_pkg::res_t r;
		n1 = wide_t'(w.first_num);
		d1 = wide_t'(w.first_den);
		n2 = wide_t'(w.second_num);
		d2 = wide_t'(w.second_den);
		x = d1 * n2 + n1 * d2;
		y = d1 * d2;
		a = x;
		b = y;
		if (x == 0 || y == 0)
			a = wide_t'(1);
		else
			while (b != 0) begin
				t = a % b;
				a = b;
				b = t;
			end
		r.sum_num = x / a;
		q = y / a;
		r.sum_den = q[rfa_pkg::DEN_W-1:0];
		return r;
	endfunction

	function void note_operands(rfa_pkg::opnd_t w);
		pending_sums.push_back(reduced_sum(w));
	endfunction

	function void check_sum(rfa_pkg::res_t got);
		rfa_pkg::res_t want;
		if (pending_sums.size() == 0) begin
			$display("%0t: result %0d/%0d with nothing pending", $time,
				got.sum_num, got.sum_den);
			errors++;
			return;
		end
		want = pending_sums.pop_front();
		if (got.sum_num !== want.sum_num) begin
			$display("%0t: sum_num expected %0d got %0d", $time,
				want.sum_num, got.sum_num);
			errors++;
		end
		if (got.sum_den !== want.sum_den) begin
			$display("%0t: sum_den expected %0d got %0d", $time,
				want.sum_den, got.sum_den);
			errors++;
		end
	endfunction
endclass

module tb;
	import rfa_pkg::*;

	localparam int IDLE_LIMIT   = 2000;
	localparam int DRAIN_CYCLES = 150;
	localparam int RANDOM_ITEMS = 900;

	logic clk = 1'b0;
	logic arst_n;
	logic opnd_valid;
	logic opnd_stall;
	opnd_t opnd;
	logic res_valid;
	logic res_stall;
	res_t res;

	sum_scoreboard sb = new;
	opnd_t operand_list[$];
	int idle_cycles = 0;

	reduced_fraction_adder dut (
		.clk(clk),
		.arst_n(arst_n),
		.opnd_valid(opnd_valid),
		.opnd_stall(opnd_stall),
		.opnd(opnd),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res(res)
	);

	always #5 clk = ~clk;

	function automatic void push_fractions(int n1, int d1, int n2, int d2);
		opnd_t w;
		w.first_num = OPND_W'(n1);
		w.first_den = OPND_W'(d1);
		w.second_num = OPND_W'(n2);
		w.second_den = OPND_W'(d2);
		operand_list.push_back(w);
	endfunction

	// Mix of full-range, small, shared-factor, power-of-two, edge and same-fraction values
	function automatic opnd_t random_operands();
		opnd_t w;
		int k;
		w.first_num = OPND_W'($urandom);
		w.first_den = OPND_W'($urandom_range(1, 65535));
		w.second_num = OPND_W'($urandom);
		w.second_den = OPND_W'($urandom_range(1, 65535));
		case ($urandom_range(0, 9))
			0, 1, 2: ;
			3, 4: begin
				w.first_num = OPND_W'($urandom_range(0, 20));
				w.first_den = OPND_W'($urandom_range(1, 20));
				w.second_num = OPND_W'($urandom_range(0, 20));
				w.second_den = OPND_W'($urandom_range(1, 20));
			end
			5, 6: begin
				k = $urandom_range(2, 255);
				w.first_num = OPND_W'(k * $urandom_range(0, 255));
				w.first_den = OPND_W'(k * $urandom_range(1, 255));
				w.second_num = OPND_W'(k * $urandom_range(0, 255));
				w.second_den = OPND_W'($urandom_range(1, 255) * $urandom_range(1, 255));
			end
			7: begin
				w.first_num = OPND_W'(1 << $urandom_range(0, OPND_W - 1));
				w.first_den = OPND_W'(1 << $urandom_range(0, OPND_W - 1));
				w.second_num = OPND_W'(1 << $urandom_range(0, OPND_W - 1));
				w.second_den = OPND_W'(1 << $urandom_range(0, OPND_W - 1));
			end
			8: begin
				w.first_num = OPND_W'($urandom_range(0, 1)
					? {OPND_W{1'b1}} - $urandom_range(0, 1) : $urandom_range(0, 1));
				w.first_den = OPND_W'($urandom_range(0, 1)
					? {OPND_W{1'b1}} - $urandom_range(0, 1) : $urandom_range(1, 2));
				w.second_num = OPND_W'($urandom_range(0, 1)
					? {OPND_W{1'b1}} - $urandom_range(0, 1) : $urandom_range(0, 1));
				w.second_den = OPND_W'($urandom_range(0, 1)
					? {OPND_W{1'b1}} - $urandom_range(0, 1) : $urandom_range(1, 2));
			end
			default: begin
				// same fraction twice
				w.second_num = w.first_num;
				w.second_den = w.first_den;
			end
		endcase
		return w;
	endfunction

	// Present one word after an idle gap, hold it until accepted
	task automatic send_operands(input opnd_t w, input int gap);
		if (gap > 0) begin
			opnd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		opnd <= w;
		opnd_valid <= 1'b1;
		do @(posedge clk); while (opnd_stall !== 1'b0);
		sb.note_operands(w);
		@(negedge clk);
	endtask

	// Operand side: reset, directed words, random words, then drain
	initial begin
		int gap;
		bit quiet;
		quiet = 1'b0;
		arst_n = 1'b0;
		opnd_valid = 1'b0;
		opnd = '0;

		// zero sums, extremes, no reduction, full reduction, zero denominators
		push_fractions(0, 1, 0, 1);
		push_fractions(0, 65535, 0, 65535);
		push_fractions(65535, 1, 65535, 1);
		push_fractions(65535, 65535, 65535, 65535);
		push_fractions(65535, 1, 65535, 65535);
		push_fractions(0, 1, 65535, 65535);
		push_fractions(1, 65535, 1, 65534);
		push_fractions(1, 2, 1, 2);
		push_fractions(3, 4, 5, 6);
		push_fractions(1, 3, 2, 3);
		push_fractions(21, 34, 34, 55);
		push_fractions(65521, 65519, 65519, 65521);
		push_fractions(32768, 16384, 8192, 32768);
		push_fractions(65534, 65534, 1, 1);
		push_fractions(43690, 21845, 21845, 43690);
		push_fractions(1, 1, 0, 65535);
		push_fractions(5, 0, 7, 3);
		push_fractions(0, 0, 0, 0);
		push_fractions(65535, 0, 65535, 0);
		push_fractions(1, 0, 0, 65535);
		repeat (RANDOM_ITEMS) operand_list.push_back(random_operands());

		repeat (7) @(negedge clk);
		arst_n <= 1'b1;

		foreach (operand_list[i]) begin
			if ($urandom_range(0, 39) == 0)
				quiet = !quiet;
			gap = quiet ? 0 : $urandom_range(0, 16);
			send_operands(operand_list[i], gap);
		end
		opnd_valid <= 1'b0;

		while (sb.pending_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Result side: each word waits a drawn number of stalled cycles
	initial begin
		int hold;
		bit quiet;
		hold = 0;
		quiet = 1'b0;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			res_stall <= (hold > 0);
			@(posedge clk);
			if (arst_n && res_valid === 1'b1) begin
				if (!res_stall) begin
					sb.check_sum(res);
					if ($urandom_range(0, 39) == 0)
						quiet = !quiet;
					hold = quiet ? 0 : $urandom_range(0, 16);
				end else begin
					hold--;
				end
			end
		end
	end

	// Watchdog: too long without a word moving on either channel
	always @(posedge clk) begin
		if (!arst_n)
			idle_cycles <= 0;
		else if ((opnd_valid && !opnd_stall) || (res_valid && !res_stall))
			idle_cycles <= 0;
		else if (idle_cycles == IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

endmodule
